// File: design/sfgm_pkg.sv
package sfgm_pkg;

	// fixed field widths
	localparam int REL_W      = 3;
	localparam int BOUND_W    = 16;
	localparam int FRAG_LEN_W = 14;
	localparam int IN_FIELD_W = REL_W + 2 * BOUND_W + FRAG_LEN_W;
	localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

	// parameter defaults
	localparam int GAP_WIDTH_DEF    = 24;
	localparam int LENGTH_WIDTH_DEF = 14;

	// min_keep_length after reset
	localparam logic [FRAG_LEN_W-1:0] MIN_KEEP_RST = FRAG_LEN_W'(32);

	// queue between front and back
	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	typedef enum logic [REL_W-1:0] {
		REL_STAR   = 3'd0,
		REL_EXACT  = 3'd1,
		REL_MAX    = 3'd2,
		REL_MIN    = 3'd3,
		REL_MINMAX = 3'd4
	} rel_t;

	// what the back end does with one fragment
	typedef enum logic [2:0] {
		ACT_DROP_SKIP,   // dropped before first kept fragment of the rule
		ACT_DROP_NEW,    // dropped, opens a new pending gap
		ACT_DROP_MERGE,  // dropped, extends the pending gap
		ACT_KEEP_FIRST,  // first kept fragment of the rule, gets star
		ACT_KEEP_PLAIN,  // kept, own relation as given
		ACT_KEEP_MERGE   // kept, relation merged across the pending gap
	} act_t;

	// one classified fragment, relation already normalized
	typedef struct packed {
		act_t                  act;
		rel_t                  rtype;
		logic [BOUND_W-1:0]    rmin;
		logic [BOUND_W-1:0]    rmax;
		logic [FRAG_LEN_W-1:0] flen;
	} fq_entry_t;

endpackage

// File: design/sfgm_front.sv
module sfgm_front
	import sfgm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [FRAG_LEN_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  q_full,
	output logic                  q_push,
	output fq_entry_t             q_entry
);

	logic [FRAG_LEN_W-1:0] min_keep_q;
	logic                  awaiting_q;
	logic                  prev_drop_q;

	logic [REL_W-1:0]      raw_type;
	logic [BOUND_W-1:0]    raw_min;
	logic [BOUND_W-1:0]    raw_max;
	logic [FRAG_LEN_W-1:0] flen;
	logic                  keep;
	logic                  awaiting_eff;
	logic                  prev_drop_eff;

	assign raw_type = s_tdata[REL_W-1:0];
	assign raw_min  = s_tdata[REL_W +: BOUND_W];
	assign raw_max  = s_tdata[REL_W + BOUND_W +: BOUND_W];
	assign flen     = s_tdata[REL_W + 2 * BOUND_W +: FRAG_LEN_W];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	// rule start overrides the per-rule flags
	assign awaiting_eff  = s_tuser || awaiting_q;
	assign prev_drop_eff = !s_tuser && prev_drop_q;
	assign keep          = (flen >= min_keep_q);

	// normalize relation: unused bounds forced to zero, bad codes to star
	always_comb begin
		q_entry.flen = flen;
		case (raw_type)
			REL_EXACT: begin
				q_entry.rtype = REL_EXACT;
				q_entry.rmin  = raw_min;
				q_entry.rmax  = '0;
			end
			REL_MAX: begin
				q_entry.rtype = REL_MAX;
				q_entry.rmin  = '0;
				q_entry.rmax  = raw_max;
			end
			REL_MIN: begin
				q_entry.rtype = REL_MIN;
				q_entry.rmin  = raw_min;
				q_entry.rmax  = '0;
			end
			REL_MINMAX: begin
				q_entry.rtype = REL_MINMAX;
				q_entry.rmin  = raw_min;
				q_entry.rmax  = raw_max;
			end
			default: begin
				q_entry.rtype = REL_STAR;
				q_entry.rmin  = '0;
				q_entry.rmax  = '0;
			end
		endcase

		// classify
		if (!keep) begin
			if (awaiting_eff)
				q_entry.act = ACT_DROP_SKIP;
			else if (prev_drop_eff)
				q_entry.act = ACT_DROP_MERGE;
			else
				q_entry.act = ACT_DROP_NEW;
		end else begin
			if (awaiting_eff)
				q_entry.act = ACT_KEEP_FIRST;
			else if (prev_drop_eff)
				q_entry.act = ACT_KEEP_MERGE;
			else
				q_entry.act = ACT_KEEP_PLAIN;
		end
	end

	// config register and per-rule flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_keep_q  <= MIN_KEEP_RST;
			awaiting_q  <= 1'b1;
			prev_drop_q <= 1'b0;
		end else begin
			if (cfg_we)
				min_keep_q <= cfg_wdata;
			if (q_push) begin
				awaiting_q  <= awaiting_eff && !keep;
				prev_drop_q <= !keep;
			end
		end
	end

endmodule

// File: design/sfgm_queue.sv
module sfgm_queue
	import sfgm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fq_entry_t push_entry,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output fq_entry_t head
);

	fq_entry_t           mem_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q;
	logic [FQ_PTR_W-1:0] rd_ptr_q;
	logic [FQ_CNT_W-1:0] count_q;

	assign full  = (count_q == FQ_CNT_W'(FQ_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/sfgm_back.sv
module sfgm_back
	import sfgm_pkg::*;
#(
	parameter int GAP_WIDTH    = GAP_WIDTH_DEF,
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
	parameter int OUT_DATA_W   = ((REL_W + 2 * GAP_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  fq_entry_t             q_head,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  m_tuser,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int SUM_W = GAP_WIDTH + 2;
	localparam int EXT_W = (LENGTH_WIDTH > FRAG_LEN_W) ? LENGTH_WIDTH : FRAG_LEN_W;
	localparam int PAD_W = OUT_DATA_W - REL_W - 2 * GAP_WIDTH;

	// pending gap, held normalized
	rel_t                    pend_type_q;
	logic [GAP_WIDTH-1:0]    pend_min_q;
	logic [GAP_WIDTH-1:0]    pend_max_q;
	logic [LENGTH_WIDTH-1:0] pend_len_q;

	// output register
	logic                    m_valid_q;
	logic                    m_keep_q;
	rel_t                    m_type_q;
	logic [GAP_WIDTH-1:0]    m_min_q;
	logic [GAP_WIDTH-1:0]    m_max_q;

	logic                    p_has_hi;
	logic                    s_has_hi;
	logic [GAP_WIDTH-1:0]    p_hi;
	logic [BOUND_W-1:0]      s_hi;
	logic [SUM_W-1:0]        lo_sum;
	logic [SUM_W-1:0]        hi_sum;
	logic [GAP_WIDTH-1:0]    lo_sat;
	logic [GAP_WIDTH-1:0]    hi_sat;
	rel_t                    mrg_type;
	logic [GAP_WIDTH-1:0]    mrg_min;
	logic [GAP_WIDTH-1:0]    mrg_max;
	logic [GAP_WIDTH-1:0]    own_min;
	logic [GAP_WIDTH-1:0]    own_max;
	logic [EXT_W-1:0]        flen_ext;
	logic [LENGTH_WIDTH-1:0] flen_sat;
	logic                    keep_d;
	rel_t                    type_d;
	logic [GAP_WIDTH-1:0]    min_d;
	logic [GAP_WIDTH-1:0]    max_d;

	assign q_pop    = !q_empty && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_keep_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_max_q, m_min_q, m_type_q};

	// upper bounds of both sides; lower bounds are the normalized min fields
	assign p_has_hi = (pend_type_q == REL_EXACT) || (pend_type_q == REL_MAX) ||
	                  (pend_type_q == REL_MINMAX);
	assign s_has_hi = (q_head.rtype == REL_EXACT) || (q_head.rtype == REL_MAX) ||
	                  (q_head.rtype == REL_MINMAX);
	assign p_hi     = (pend_type_q == REL_EXACT) ? pend_min_q : pend_max_q;
	assign s_hi     = (q_head.rtype == REL_EXACT) ? q_head.rmin : q_head.rmax;

	// gap sums across the dropped fragment, saturating
	assign lo_sum = SUM_W'(pend_min_q) + SUM_W'(pend_len_q) + SUM_W'(q_head.rmin);
	assign hi_sum = SUM_W'(p_hi) + SUM_W'(pend_len_q) + SUM_W'(s_hi);
	assign lo_sat = (lo_sum[SUM_W-1:GAP_WIDTH] != '0) ? '1 : lo_sum[GAP_WIDTH-1:0];
	assign hi_sat = (hi_sum[SUM_W-1:GAP_WIDTH] != '0) ? '1 : hi_sum[GAP_WIDTH-1:0];

	// merged relation
	always_comb begin
		mrg_min = lo_sat;
		if ((pend_type_q == REL_EXACT) && (q_head.rtype == REL_EXACT)) begin
			mrg_type = REL_EXACT;
			mrg_max  = '0;
		end else if (p_has_hi && s_has_hi) begin
			mrg_type = REL_MINMAX;
			mrg_max  = hi_sat;
		end else begin
			mrg_type = REL_MIN;
			mrg_max  = '0;
		end
	end

	assign own_min = GAP_WIDTH'(q_head.rmin);
	assign own_max = GAP_WIDTH'(q_head.rmax);

	// dropped length kept at LENGTH_WIDTH, saturating
	assign flen_ext = EXT_W'(q_head.flen);
	assign flen_sat = (flen_ext > EXT_W'({LENGTH_WIDTH{1'b1}})) ? '1
	                                                            : flen_ext[LENGTH_WIDTH-1:0];

	// result per action
	always_comb begin
		keep_d = 1'b0;
		type_d = REL_STAR;
		min_d  = '0;
		max_d  = '0;
		case (q_head.act)
			ACT_KEEP_FIRST: begin
				keep_d = 1'b1;
			end
			ACT_KEEP_PLAIN: begin
				keep_d = 1'b1;
				type_d = q_head.rtype;
				min_d  = own_min;
				max_d  = own_max;
			end
			ACT_KEEP_MERGE: begin
				keep_d = 1'b1;
				type_d = mrg_type;
				min_d  = mrg_min;
				max_d  = mrg_max;
			end
			default: begin
				keep_d = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_keep_q  <= 1'b0;
			m_type_q  <= REL_STAR;
			m_min_q   <= '0;
			m_max_q   <= '0;
		end else if (q_pop) begin
			m_valid_q <= 1'b1;
			m_keep_q  <= keep_d;
			m_type_q  <= type_d;
			m_min_q   <= min_d;
			m_max_q   <= max_d;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// pending gap update on dropped fragments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_type_q <= REL_STAR;
			pend_min_q  <= '0;
			pend_max_q  <= '0;
			pend_len_q  <= '0;
		end else if (q_pop) begin
			case (q_head.act)
				ACT_DROP_NEW: begin
					pend_type_q <= q_head.rtype;
					pend_min_q  <= own_min;
					pend_max_q  <= own_max;
					pend_len_q  <= flen_sat;
				end
				ACT_DROP_MERGE: begin
					pend_type_q <= mrg_type;
					pend_min_q  <= mrg_min;
					pend_max_q  <= mrg_max;
					pend_len_q  <= flen_sat;
				end
				default: begin
					pend_type_q <= pend_type_q;
				end
			endcase
		end
	end

endmodule

// File: design/short_fragment_gap_merger.sv
// Short fragment gap merger.
// Input stream: one beat per signature fragment. s_tuser is the rule-start
// flag; s_tdata carries the gap relation to the previous fragment and the
// fragment length. Output stream: exactly one beat per input beat, in order.
// m_tuser is the keep flag; a dropped fragment gives all-zero m_tdata, a kept
// one the relation to print, merged across any fragments dropped before it.
// cfg_we/cfg_wdata write min_keep_length (fragments shorter are dropped);
// write it only while the block is idle.
// An accepted beat is written into the queue and then registered into the
// output register when the output path is free. Throughput is one beat per
// cycle while the receiver takes beats; the back-end merge adder is combinational.
// A four-entry queue sits between the classifying front end and the merging
// back end; when the receiver stalls, the output beat holds, the queue fills,
// and s_tready drops only when the queue is full.
// Reset: min_keep_length returns to 32, the queue and output empty, and the
// block waits for the first kept fragment of a rule. Beats are accepted as
// soon as reset is released.
module short_fragment_gap_merger
	import sfgm_pkg::*;
#(
	parameter int GAP_WIDTH    = GAP_WIDTH_DEF,
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [FRAG_LEN_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_tuser,  // rule_start
	input  logic [IN_DATA_W-1:0]  s_tdata,  // rel_type, rel_min, rel_max, frag_length
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  m_tuser,  // keep
	output logic [((REL_W + 2 * GAP_WIDTH + 7) / 8) * 8 - 1:0]
	                              m_tdata   // out_type, out_min, out_max
);

	localparam int OUT_DATA_W = ((REL_W + 2 * GAP_WIDTH + 7) / 8) * 8;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	fq_entry_t q_in;
	fq_entry_t q_head;

	sfgm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	sfgm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	sfgm_back #(
		.GAP_WIDTH    (GAP_WIDTH),
		.LENGTH_WIDTH (LENGTH_WIDTH),
		.OUT_DATA_W   (OUT_DATA_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule

// File: design/sfgm_checker.sv
module sfgm_checker
	import sfgm_pkg::*;
#(
	parameter int GAP_WIDTH = GAP_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic                  m_tuser,
	input logic [((REL_W + 2 * GAP_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int OUT_DATA_W = ((REL_W + 2 * GAP_WIDTH + 7) / 8) * 8;

	logic [REL_W-1:0]     o_type;
	logic [GAP_WIDTH-1:0] o_min;
	logic [GAP_WIDTH-1:0] o_max;

	assign o_type = m_tdata[REL_W-1:0];
	assign o_min  = m_tdata[REL_W +: GAP_WIDTH];
	assign o_max  = m_tdata[REL_W + GAP_WIDTH +: GAP_WIDTH];

	// stalled beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// dropped fragment carries no relation
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == OUT_DATA_W'(0))
		else $error("dropped beat with nonzero data");

	// star relation has no bounds
	a_star_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && o_type == REL_STAR |-> o_min == '0 && o_max == '0)
		else $error("star beat with bounds");

	// exact and min relations have no upper bound; max has no lower bound
	a_unused_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && (o_type == REL_EXACT || o_type == REL_MIN)
		|-> o_max == '0)
		else $error("upper bound set on exact or min beat");

	a_max_no_lo: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && o_type == REL_MAX |-> o_min == '0)
		else $error("lower bound set on max beat");

endmodule

bind short_fragment_gap_merger sfgm_checker #(
	.GAP_WIDTH (GAP_WIDTH)
) u_sfgm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);
